// ===== rtl/pcs_pkg.sv =====
package pcs_pkg;

  localparam int COORD_FRAC_BITS_DEF  = 16;
  localparam int ANGLE_ITERATIONS_DEF = 16;

  // Coordinate differences and CORDIC datapath widths.
  localparam int DIFF_W    = 33;
  localparam int CW        = 37;
  localparam int ANG_W     = 32;
  localparam int ANG_ABS_W = 27;
  localparam int MAG_W     = 34;
  localparam int LEN_W     = MAG_W + 1;
  localparam int CURV_W    = 24;
  localparam int MAXC_W    = 23;
  localparam int COORD_W   = 32;

  // Angles in radians, Q.24.
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 32'sd26353589;
  localparam logic signed [ANG_W-1:0] ANG_PI      = 32'sd52707179;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 32'sd105414357;

  // Inverse CORDIC gain, Q30.
  localparam int GAIN_W = 30;
  localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032874;

  localparam logic [MAXC_W-1:0] MAX_CURV_RESET = 23'd131072;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ITER,
    CS_MUL0,
    CS_MUL1
  } cord_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CSTART,
    ST_CWAIT0,
    ST_CWAIT1,
    ST_DSTART,
    ST_DWAIT,
    ST_EMIT
  } top_state_t;

  function automatic logic signed [ANG_W-1:0] atan_q24(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'sd13176795;
      5'd1:  v = 32'sd7778716;
      5'd2:  v = 32'sd4110060;
      5'd3:  v = 32'sd2086331;
      5'd4:  v = 32'sd1047214;
      5'd5:  v = 32'sd524117;
      5'd6:  v = 32'sd262123;
      5'd7:  v = 32'sd131069;
      5'd8:  v = 32'sd65536;
      5'd9:  v = 32'sd32768;
      5'd10: v = 32'sd16384;
      5'd11: v = 32'sd8192;
      5'd12: v = 32'sd4096;
      5'd13: v = 32'sd2048;
      5'd14: v = 32'sd1024;
      5'd15: v = 32'sd512;
      5'd16: v = 32'sd256;
      5'd17: v = 32'sd128;
      5'd18: v = 32'sd64;
      5'd19: v = 32'sd32;
      5'd20: v = 32'sd16;
      5'd21: v = 32'sd8;
      5'd22: v = 32'sd4;
      5'd23: v = 32'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/path_curvature_stream.sv =====
// A point that only fills the history is taken without a turn evaluation; a point
// with two held neighbors presents its first result after two CORDIC passes and,
// unless the arc is degenerate, the bit-serial divider, then one per cycle while out_ready is high.
// One request at a time: in_ready stays low until the last result is loaded.
// Reset (rst_n low, synchronous) empties the history, drops pending results and
// sets the curvature clamp to 2.0 rad/m.
module path_curvature_stream #(
  parameter int COORD_FRAC_BITS  = pcs_pkg::COORD_FRAC_BITS_DEF,
  parameter int ANGLE_ITERATIONS = pcs_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pcs_pkg::COORD_W-1:0]    in_point_x,
  input  logic signed [pcs_pkg::COORD_W-1:0]    in_point_y,
  input  logic                                  in_last_point,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pcs_pkg::CURV_W-1:0]     out_curvature,
  output logic                                  out_end_of_path,
  output logic                                  out_last_of_run,
  input  logic                                  cfg_wr_en,
  input  logic        [pcs_pkg::MAXC_W-1:0]     cfg_wr_data
);
  import pcs_pkg::*;

  // The dividend is |dtheta| (Q.24) scaled so that the quotient lands in Q8.16.
  localparam int SHIFT = COORD_FRAC_BITS - 7;
  localparam int DVD_W = ANG_ABS_W + SHIFT;
  // Mean arc below 1e-6 m, written as a bound on the summed lengths.
  localparam logic [LEN_W-1:0] ZERO_LIM =
    LEN_W'(((64'd1 << COORD_FRAC_BITS) - 64'd1) / 64'd500000);

  top_state_t state_r, state_nxt;

  logic [MAXC_W-1:0] max_curv_r;
  logic [1:0]        ps_r;
  logic signed [COORD_W-1:0] older_x_r, older_y_r, newer_x_r, newer_y_r;
  logic signed [DIFF_W-1:0]  dx0_r, dy0_r, dx1_r, dy1_r;
  logic signed [ANG_W-1:0]   a1_r, d_r;
  logic [MAG_W-1:0]          m1_r;
  logic [LEN_W-1:0]          len_r;
  logic signed [CURV_W-1:0]  c_r;
  logic [1:0]                n_r;
  logic                      lastp_r;

  logic                      out_valid_r, out_end_r, out_lor_r;
  logic signed [CURV_W-1:0]  out_curv_r;

  logic accept, needs_calc, emit_load;
  logic cord_start, cord_done, div_start, div_done;
  logic signed [DIFF_W-1:0] cord_dx, cord_dy;
  logic signed [ANG_W-1:0]  cord_ang, d_diff, d_wrap;
  logic [MAG_W-1:0]         cord_mag;
  logic [ANG_W-1:0]         d_abs;
  logic [DVD_W-1:0]         div_q, q_clamp, dividend;
  logic signed [CURV_W-1:0] q_signed;
  logic [1:0]               n_calc;

  assign accept     = in_valid && in_ready;
  // The third and later points of a path carry a turn to evaluate.
  assign needs_calc = ps_r[1];
  assign n_calc     = 2'(ps_r == 2'd2) + 2'd1 + 2'(in_last_point);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (needs_calc) state_nxt = ST_CSTART;
          else if (in_last_point) state_nxt = ST_EMIT;
        end
      end
      ST_CSTART: state_nxt = ST_CWAIT0;
      ST_CWAIT0: if (cord_done) state_nxt = ST_CWAIT1;
      ST_CWAIT1: if (cord_done) state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = (len_r <= ZERO_LIM) ? ST_EMIT : ST_DWAIT;
      ST_DWAIT:  if (div_done) state_nxt = ST_EMIT;
      ST_EMIT:   if (emit_load && n_r == 2'd1) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    cord_start = (state_r == ST_CSTART) || (state_r == ST_CWAIT0 && cord_done);
    div_start  = (state_r == ST_DSTART) && (len_r > ZERO_LIM);
    emit_load  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  end

  assign cord_dx = (state_r == ST_CSTART) ? dx0_r : dx1_r;
  assign cord_dy = (state_r == ST_CSTART) ? dy0_r : dy1_r;

  pcs_cordic #(
    .ITER (ANGLE_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .dx    (cord_dx),
    .dy    (cord_dy),
    .done  (cord_done),
    .ang   (cord_ang),
    .mag   (cord_mag)
  );

  // Heading change, wrapped into [-pi, pi].
  always_comb begin
    d_diff = cord_ang - a1_r;
    d_wrap = d_diff;
    if (d_wrap > ANG_PI) d_wrap = d_wrap - ANG_TWO_PI;
    if (d_wrap < -ANG_PI) d_wrap = d_wrap + ANG_TWO_PI;
  end

  assign d_abs    = d_r[ANG_W-1] ? ANG_W'(-d_r) : ANG_W'(d_r);
  assign dividend = DVD_W'(d_abs[ANG_ABS_W-1:0]) << SHIFT;

  pcs_div #(
    .DVD_W (DVD_W),
    .DVS_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (len_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_clamp  = (div_q > DVD_W'(max_curv_r)) ? DVD_W'(max_curv_r) : div_q;
  assign q_signed = d_r[ANG_W-1] ? -CURV_W'(q_clamp[MAXC_W-1:0])
                                 : CURV_W'(q_clamp[MAXC_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ps_r        <= 2'd0;
      max_curv_r  <= MAX_CURV_RESET;
      out_valid_r <= 1'b0;
      older_x_r   <= '0;
      older_y_r   <= '0;
      newer_x_r   <= '0;
      newer_y_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) max_curv_r <= cfg_wr_data;

      // Point history moves on each accepted request and clears at path end.
      if (accept) begin
        if (in_last_point) begin
          ps_r      <= 2'd0;
          older_x_r <= '0;
          older_y_r <= '0;
          newer_x_r <= '0;
          newer_y_r <= '0;
        end else begin
          ps_r      <= needs_calc ? 2'd3 : ps_r + 2'd1;
          older_x_r <= newer_x_r;
          older_y_r <= newer_y_r;
          newer_x_r <= in_point_x;
          newer_y_r <= in_point_y;
        end
      end

      if (emit_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      dx0_r   <= DIFF_W'(newer_x_r) - DIFF_W'(older_x_r);
      dy0_r   <= DIFF_W'(newer_y_r) - DIFF_W'(older_y_r);
      dx1_r   <= DIFF_W'(in_point_x) - DIFF_W'(newer_x_r);
      dy1_r   <= DIFF_W'(in_point_y) - DIFF_W'(newer_y_r);
      lastp_r <= in_last_point;
      // Short paths give zeros: one for a lone point, two for a pair.
      n_r     <= needs_calc ? n_calc : (ps_r[0] ? 2'd2 : 2'd1);
      c_r     <= '0;
    end
    if (state_r == ST_CWAIT0 && cord_done) begin
      a1_r <= cord_ang;
      m1_r <= cord_mag;
    end
    if (state_r == ST_CWAIT1 && cord_done) begin
      d_r   <= d_wrap;
      len_r <= LEN_W'(m1_r) + LEN_W'(cord_mag);
    end
    if (state_r == ST_DWAIT && div_done) c_r <= q_signed;
    if (emit_load) begin
      out_curv_r <= c_r;
      out_end_r  <= lastp_r && (n_r == 2'd1);
      out_lor_r  <= (n_r == 2'd1);
      n_r        <= n_r - 2'd1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_curvature   = out_curv_r;
  assign out_end_of_path = out_end_r;
  assign out_last_of_run = out_lor_r;

  // A result never exceeds the clamp magnitude.
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_curvature <= $signed({1'b0, max_curv_r})) &&
                  (out_curvature >= -$signed({1'b0, max_curv_r})))
    else $error("curvature beyond clamp");

  // The final point's result is always the last of its run.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_path) |-> out_last_of_run)
    else $error("end_of_path without last_of_run");

  // A final point empties the history.
  a_hist_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_point) |=> (ps_r == 2'd0))
    else $error("history not cleared at path end");

endmodule

// ===== rtl/pcs_cordic.sv =====
module pcs_cordic #(
  parameter int ITER = pcs_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [pcs_pkg::DIFF_W-1:0]    dx,
  input  logic signed [pcs_pkg::DIFF_W-1:0]    dy,
  output logic                                 done,
  output logic signed [pcs_pkg::ANG_W-1:0]     ang,
  output logic        [pcs_pkg::MAG_W-1:0]     mag
);
  import pcs_pkg::*;

  localparam int IW    = $clog2(ITER);
  localparam int LO_W  = 18;
  localparam int HI_W  = CW - LO_W;
  localparam int OP_W  = HI_W;
  localparam int PRD_W = OP_W + GAIN_W;
  localparam int ACC_W = CW + GAIN_W;

  cord_state_t state_r, state_nxt;
  logic signed [CW-1:0]    x_r, y_r;
  logic signed [ANG_W-1:0] z_r;
  logic [IW-1:0]           cnt_r;
  logic                    zero_r;
  logic [ACC_W-1:0]        acc_r;
  logic                    done_r;

  logic signed [CW-1:0] x0, y0, xs, ys;
  logic signed [ANG_W-1:0] z0;
  logic signed [CW-1:0] dxe, dye;
  logic [OP_W-1:0]  mop;
  logic [PRD_W-1:0] prod;
  logic iter_en, mul_first, mul_second, last_iter;

  assign dxe = CW'(dx);
  assign dye = CW'(dy);
  assign last_iter = (cnt_r == IW'(ITER - 1));

  // Pre-rotation into the right half plane.
  always_comb begin
    x0 = dxe;
    y0 = dye;
    z0 = '0;
    if (dxe < 0) begin
      if (dye >= 0) begin
        x0 = dye;
        y0 = -dxe;
        z0 = ANG_HALF_PI;
      end else begin
        x0 = -dye;
        y0 = dxe;
        z0 = -ANG_HALF_PI;
      end
    end
  end

  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: if (start) state_nxt = CS_ITER;
      CS_ITER: if (last_iter) state_nxt = CS_MUL0;
      CS_MUL0: state_nxt = CS_MUL1;
      CS_MUL1: state_nxt = CS_IDLE;
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    iter_en    = (state_r == CS_ITER);
    mul_first  = (state_r == CS_MUL0);
    mul_second = (state_r == CS_MUL1);
  end

  // One multiplier, shared by the low and high halves of the final x.
  assign mop  = mul_first ? OP_W'(x_r[LO_W-1:0]) : OP_W'(x_r[CW-1:LO_W]);
  assign prod = PRD_W'(mop) * PRD_W'(INV_GAIN_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= mul_second;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == CS_IDLE && start) begin
      x_r    <= x0;
      y_r    <= y0;
      z_r    <= z0;
      cnt_r  <= '0;
      zero_r <= (dx == 0) && (dy == 0);
    end else if (iter_en) begin
      if (y_r >= 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_q24(5'(cnt_r));
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_q24(5'(cnt_r));
      end
      cnt_r <= cnt_r + 1'b1;
    end
    if (mul_first) begin
      acc_r <= ACC_W'(prod);
    end else if (mul_second) begin
      acc_r <= acc_r + (ACC_W'(prod) << LO_W);
    end
  end

  assign done = done_r;
  assign ang  = zero_r ? '0 : z_r;
  assign mag  = (zero_r || x_r[CW-1]) ? '0 : acc_r[GAIN_W +: MAG_W];

endmodule

// ===== rtl/pcs_div.sv =====
module pcs_div #(
  parameter int DVD_W = 36,
  parameter int DVS_W = pcs_pkg::LEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  import pcs_pkg::*;

  localparam int NW = $clog2(DVD_W);

  logic             busy_r, done_r;
  logic [NW-1:0]    cnt_r;
  logic [DVS_W-1:0] rem_r, dvs_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W:0]   sh, diff;
  logic             take;

  // Restoring division, one quotient bit per cycle.
  assign sh   = {rem_r, quo_r[DVD_W-1]};
  assign diff = sh - {1'b0, dvs_r};
  assign take = (sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == NW'(DVD_W - 1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == NW'(DVD_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], take};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== tb/tb_path_curvature_stream.sv =====
module tb_path_curvature_stream;
  timeunit 1ns;
  timeprecision 1ps;

  import pcs_pkg::*;

  // One result of the block, as the predictor sees it.
  typedef struct packed {
    logic signed [CURV_W-1:0] curvature;
    logic                     end_of_path;
    logic                     last_of_run;
  } curv_result_t;

  // Predicts the block's curvature results from accepted points and checks
  // the results that come out against them, oldest first.
  class curvature_scoreboard;
    curv_result_t   pending[$];
    int             errors;
    logic [MAXC_W-1:0] clamp_limit;
    longint         prev_x, prev_y, held_x, held_y;
    int             held_count;

    function new();
      errors = 0;
      clamp_limit = MAX_CURV_RESET;
      clear_path();
    endfunction

    function void clear_path();
      prev_x = 0; prev_y = 0; held_x = 0; held_y = 0;
      held_count = 0;
    endfunction

    function void set_limit(logic [MAXC_W-1:0] v);
      clamp_limit = v;
    endfunction

    static function longint asr(longint v, int s);
      return v >>> s;
    endfunction

    // Vectoring CORDIC: heading (Q.24 rad) and gain-corrected length.
    function void heading_length(longint dx, longint dy, output longint ang,
                                 output longint len);
      longint x, y, z, t, xs, ys;
      longint atans[16];
      logic [63:0] prod;
      atans = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};
      x = dx; y = dy; z = 0;
      if (dx == 0 && dy == 0) begin
        ang = 0; len = 0;
        return;
      end
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = ANG_HALF_PI;
        end else begin
          x = -y; y = t; z = -ANG_HALF_PI;
        end
      end
      for (int i = 0; i < 16; i++) begin
        xs = asr(x, i); ys = asr(y, i);
        if (y >= 0) begin
          x = x + ys; y = y - xs; z = z + atans[i];
        end else begin
          x = x - ys; y = y + xs; z = z - atans[i];
        end
      end
      ang = z;
      prod = 64'(x) * 64'(INV_GAIN_Q30);
      len = (x < 0) ? 0 : longint'(prod >> 30);
    endfunction

    // Turning angle over mean segment length, clamped.
    function logic signed [CURV_W-1:0] turn_rate(longint ax, longint ay,
        longint bx, longint by, longint cx, longint cy);
      longint a1, a2, m1, m2, d, arc, q;
      logic [63:0] num;
      heading_length(bx - ax, by - ay, a1, m1);
      heading_length(cx - bx, cy - by, a2, m2);
      d = a2 - a1;
      if (d > ANG_PI) d = d - ANG_TWO_PI;
      if (d < -ANG_PI) d = d + ANG_TWO_PI;
      arc = m1 + m2;
      // Degenerate arc: mean length under a micrometre gives zero.
      if (arc * 500000 < (longint'(1) << 16)) return '0;
      num = 64'(d < 0 ? -d : d) << 9;
      q = longint'(num / 64'(arc));
      if (q > longint'(clamp_limit)) q = clamp_limit;
      return CURV_W'(d < 0 ? -q : q);
    endfunction

    function void push(logic signed [CURV_W-1:0] c, logic eop);
      curv_result_t r;
      r.curvature = c; r.end_of_path = eop; r.last_of_run = 1'b0;
      pending.insert(pending.size(), r);
    endfunction

    // Notes one accepted point and queues the results it causes.
    function void note_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic last);
      int size_at_entry;
      logic signed [CURV_W-1:0] c;
      curv_result_t r;
      size_at_entry = pending.size();
      if (held_count == 0) begin
        if (last) push('0, 1'b1);
        else begin
          held_x = x; held_y = y; held_count = 1;
        end
      end else if (held_count == 1) begin
        if (last) begin
          push('0, 1'b0); push('0, 1'b1);
        end else begin
          prev_x = held_x; prev_y = held_y;
          held_x = x; held_y = y; held_count = 2;
        end
      end else begin
        c = turn_rate(prev_x, prev_y, held_x, held_y, x, y);
        if (held_count == 2) push(c, 1'b0);
        push(c, 1'b0);
        if (last) push(c, 1'b1);
        prev_x = held_x; prev_y = held_y;
        held_x = x; held_y = y; held_count = 3;
      end
      if (last) clear_path();
      if (pending.size() > size_at_entry) begin
        r = pending[pending.size() - 1];
        r.last_of_run = 1'b1;
        pending[pending.size() - 1] = r;
      end
    endfunction

    function void check_result(curv_result_t got);
      curv_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.curvature !== want.curvature) begin
        $display("%0t: curvature expected %0d actual %0d", $time,
                 want.curvature, got.curvature);
        errors++;
      end
      if (got.end_of_path !== want.end_of_path) begin
        $display("%0t: end_of_path expected %0b actual %0b", $time,
                 want.end_of_path, got.end_of_path);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run expected %0b actual %0b", $time,
                 want.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, in_last_point;
  logic signed [COORD_W-1:0] in_point_x, in_point_y;
  logic out_valid, out_ready, out_end_of_path, out_last_of_run;
  logic signed [CURV_W-1:0] out_curvature;
  logic cfg_wr_en;
  logic [MAXC_W-1:0] cfg_wr_data;

  curvature_scoreboard sb;
  longint cycle_count;
  localparam longint CYCLE_LIMIT = 400000;

  path_curvature_stream DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_last_point(in_last_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_curvature(out_curvature), .out_end_of_path(out_end_of_path),
    .out_last_of_run(out_last_of_run),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a generous cycle budget covering every request's worst-case
  // processing, its gaps and three maximally stalled results.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: check each accepted result, then draw a fresh stall so
  // that back-pressure lands on every phase of the block's output.
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_result('{out_curvature, out_end_of_path, out_last_of_run});
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end
      out_ready <= (stall_left == 0);
    end
  end

  int gap_max;

  // Send one point request; waits a random gap first, then holds valid
  // until the block accepts it. Valid stays high into a gapless next request.
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic last);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_last_point <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_point(x, y, last);
  endtask

  // Let every expected result drain, then allow the block's latency to pass
  // in case a request that caused nothing is still being processed.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_limit(logic [MAXC_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_limit(v);
  endtask

  // A random path: mostly smooth walks with moderate steps so the clamp and
  // the turning angle both matter; sometimes wild full-range coordinates.
  task automatic send_path(int npts);
    logic signed [31:0] x, y;
    int step, mode;
    mode = $urandom_range(0, 9);
    x = $urandom; y = $urandom;
    if (mode < 7) begin
      x = $signed(x) >>> 4; y = $signed(y) >>> 4;
    end
    for (int i = 0; i < npts; i++) begin
      if (mode == 9) begin
        x = $urandom; y = $urandom;
      end else if (mode == 8 && $urandom_range(0, 2) == 0) begin
        // Repeated point: zero-length segment.
      end else begin
        step = 1 << $urandom_range(0, 20);
        x = x + $signed($urandom_range(0, 2 * step)) - step;
        y = y + $signed($urandom_range(0, 2 * step)) - step;
      end
      send_point(x, y, i == npts - 1);
    end
  endtask

  int sent;

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_last_point = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    cycle_count = 0;
    gap_max = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: short paths of one and two points, a straight line ending in a
    // right-angle turn, a reversal that clamps, a stationary path with zero arc
    // length, and coordinate extremes.
    send_point(32'sh7fffffff, 32'sh80000000, 1'b1);
    send_point(32'sh80000000, 32'sh7fffffff, 1'b0);
    send_point(32'sh7fffffff, 32'sh80000000, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(32'sh10000, 0, 1'b0);
    send_point(32'sh20000, 0, 1'b0);
    send_point(32'sh20000, 32'sh10000, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(32'sh10000, 0, 1'b0);
    send_point(0, 0, 1'b1);
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b1);
    send_point(32'sh80000000, 32'sh80000000, 1'b0);
    send_point(32'sh7fffffff, 32'sh7fffffff, 1'b0);
    send_point(32'sh80000000, 32'sh7fffffff, 1'b0);
    send_point(0, 32'shffffffff, 1'b1);
    sent = 17;

    // Random phases, each with its own clamp setting, extremes included.
    // The write_limit drain before each phase also covers the required
    // pause until every expected result has come.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_limit('0);
        1: write_limit(23'h7fffff);
        2: write_limit(23'd1);
        3: write_limit(MAX_CURV_RESET);
        default: write_limit(MAXC_W'($urandom_range(0, 23'h7fffff)));
      endcase
      gap_max = (phase % 3 == 0) ? 0 : 15;
      while (sent < 17 + 66 * (phase + 1)) begin
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
        send_path(n);
        sent = sent + n;
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
